@@ hdl/impulse_contact_resolver_macros.svh @@
// Assertion macros shared by the impulse contact resolver modules.
`ifndef IMPULSE_CONTACT_RESOLVER_MACROS_SVH
`define IMPULSE_CONTACT_RESOLVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/icr_pkg.sv @@
// Types and constants shared by the impulse contact resolver modules.
package icr_pkg;

  localparam int FIELD_W = 63;
  localparam int MASS_W  = 20;
  localparam int E_W     = 11;
  localparam int EP_W    = 12;
  localparam int E_SH    = 10;
  localparam int ACC_W   = 7;
  localparam int ACC_SH  = 10;

  localparam logic [E_W-1:0]   E_RESET   = 11'd102;
  localparam logic [EP_W-1:0]  ONE_Q10   = 12'd1024;
  localparam logic [ACC_W-1:0] NEG_TENTH = 7'd102;

  localparam int NUM_LANES = 4;
  localparam int L_KA = 0;
  localparam int L_KB = 1;
  localparam int L_DA = 2;
  localparam int L_DB = 3;

  typedef struct packed {
    logic [FIELD_W-1:0] vel_a;
    logic [FIELD_W-1:0] vel_b;
    logic [FIELD_W-1:0] pos_a;
    logic [FIELD_W-1:0] pos_b;
    logic [FIELD_W-1:0] normal;
    logic [FIELD_W-1:0] accel_a;
    logic [FIELD_W-1:0] accel_b;
    logic [MASS_W-1:0]  depth;
    logic [MASS_W-1:0]  mass_a;
    logic [MASS_W-1:0]  mass_b;
    logic               static_a;
    logic               static_b;
  } icr_item_t;

endpackage

@@ hdl/icr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes share a divisor.
module icr_div #(
  parameter int QW    = 38,
  parameter int SW    = 21,
  parameter int LANES = 4
) (
  input  logic              clk,
  input  logic              en,
  input  logic [SW-1:0]     dvsr,
  input  logic [QW+SW-1:0]  num [LANES],
  output logic [QW-1:0]     quo [LANES]
);

  logic [SW-1:0] d_c   [QW];
  logic [SW-1:0] rem_c [QW][LANES];
  logic [QW-1:0] x_c   [QW][LANES];
  logic [SW-1:0] d_r   [QW];
  logic [SW-1:0] rem_r [QW][LANES];
  logic [QW-1:0] x_r   [QW][LANES];

  function automatic logic [SW+QW-1:0] step(input logic [SW-1:0] rem,
                                            input logic [QW-1:0] x,
                                            input logic [SW-1:0] d);
    logic [SW:0] tmp;
    logic [SW:0] dif;
    tmp = {rem, x[QW-1]};
    dif = tmp - {1'b0, d};
    if (tmp >= {1'b0, d}) begin
      step = {dif[SW-1:0], x[QW-2:0], 1'b1};
    end else begin
      step = {tmp[SW-1:0], x[QW-2:0], 1'b0};
    end
  endfunction

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign d_c[k] = dvsr;
      for (genvar l = 0; l < LANES; l++) begin : g_ln
        assign rem_c[k][l] = num[l][QW+SW-1:QW];
        assign x_c[k][l]   = num[l][QW-1:0];
      end
    end else begin : g_next
      assign d_c[k] = d_r[k-1];
      for (genvar l = 0; l < LANES; l++) begin : g_ln
        assign rem_c[k][l] = rem_r[k-1][l];
        assign x_c[k][l]   = x_r[k-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k] <= d_c[k];
        for (int l = 0; l < LANES; l++) begin
          {rem_r[k][l], x_r[k][l]} <= step(rem_c[k][l], x_c[k][l], d_c[k]);
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo[l] = x_r[QW-1][l];
  end

endmodule

@@ hdl/icr_front.sv @@
// Front end: takes contacts, clamps zero masses and queues them for the datapath.
`include "impulse_contact_resolver_macros.svh"
module icr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  icr_pkg::icr_item_t in_item,
  output logic               q_vld,
  output icr_pkg::icr_item_t q_item,
  input  logic               q_pop
);
  import icr_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  icr_item_t  ent_r [2];
  icr_item_t  fix;
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;

  assign in_full = (cnt_r == DEPTH);
  assign push    = in_push && !in_full;
  assign q_vld   = (cnt_r != 2'd0);
  assign q_item  = ent_r[rp_r];

  // A zero mass is treated as one LSB.
  always_comb begin
    fix = in_item;
    if (in_item.mass_a == '0) fix.mass_a = MASS_W'(1);
    if (in_item.mass_b == '0) fix.mass_b = MASS_W'(1);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= fix;
  end

  `ICR_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= DEPTH, "queue count out of range")
  `ICR_ASSERT_NEXT(a_cnt_inc, push && !q_pop, cnt_r == $past(cnt_r) + 2'd1,
                   "queue count did not grow on push")
  `ICR_ASSERT_NEXT(a_cnt_dec, !push && q_pop, cnt_r == $past(cnt_r) - 2'd1,
                   "queue count did not shrink on pop")

endmodule

@@ hdl/icr_back.sv @@
// Back end: impulse and separation datapath with the output register.
`include "impulse_contact_resolver_macros.svh"
module icr_back #(
  parameter int CB = 21,
  parameter int FB = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [icr_pkg::E_W-1:0]     cfg_restitution,
  input  logic                        q_vld,
  input  icr_pkg::icr_item_t          q_item,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [icr_pkg::FIELD_W-1:0] new_vel_a,
  output logic [icr_pkg::FIELD_W-1:0] new_vel_b,
  output logic [icr_pkg::FIELD_W-1:0] new_pos_a,
  output logic [icr_pkg::FIELD_W-1:0] new_pos_b,
  output logic [icr_pkg::FIELD_W-1:0] new_accel_b
);
  import icr_pkg::*;

  localparam int DFW  = CB + 1;
  localparam int PRW  = DFW + CB;
  localparam int DOTW = PRW + 2;
  localparam int DPW  = DOTW + EP_W + 1;
  localparam int TMW  = DPW - FB - E_SH;
  localparam int QW   = (TMW > MASS_W) ? TMW : MASS_W;
  localparam int SW   = MASS_W + 1;
  localparam int NW   = QW + SW;
  localparam int PW2  = QW + CB;
  localparam int RW   = PW2 + 1 - FB;
  localparam int SUMW = RW + 2;
  localparam int AMW  = CB + ACC_W;
  localparam int ARW  = AMW + 1 - ACC_SH;
  localparam logic signed [SUMW-1:0] CMAX = SUMW'(2**(CB-1) - 1);
  localparam logic signed [SUMW-1:0] CMIN = SUMW'(-(2**(CB-1)));

  function automatic logic signed [CB-1:0] comp(input logic [FIELD_W-1:0] f, input int i);
    comp = $signed(f[i*CB +: CB]);
  endfunction

  function automatic logic [CB-1:0] mag(input logic [CB-1:0] v);
    mag = v[CB-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [RW-1:0] rnd(input logic [PW2-1:0] p);
    logic [PW2:0] t;
    t = (PW2+1)'(p) + ((PW2+1)'(1) << (FB - 1));
    rnd = t[PW2:FB];
  endfunction

  function automatic logic [CB-1:0] apply(input logic [CB-1:0] base,
                                          input logic [RW-1:0] r, input logic sub);
    logic signed [SUMW-1:0] b;
    logic signed [SUMW-1:0] m;
    logic signed [SUMW-1:0] s;
    b = SUMW'($signed(base));
    m = $signed({2'b00, r});
    s = sub ? (b - m) : (b + m);
    if (s > CMAX) begin
      apply = CMAX[CB-1:0];
    end else if (s < CMIN) begin
      apply = CMIN[CB-1:0];
    end else begin
      apply = s[CB-1:0];
    end
  endfunction

  logic en;
  logic [E_W-1:0] rest_r;

  // Stage 1: velocity differences times normal.
  logic signed [DFW-1:0] dif1 [3];
  logic signed [PRW-1:0] prod1_nxt [3];
  logic signed [PRW-1:0] prod1_r [3];
  icr_item_t item1_r;
  logic v1_r;
  // Stage 2: dot product.
  logic signed [DOTW-1:0] dot2_r;
  icr_item_t item2_r;
  logic v2_r;
  // Stage 3: scale by (1 + e).
  logic [EP_W-1:0] ep;
  logic signed [EP_W:0] ep_s;
  logic signed [DPW-1:0] dp3_r;
  icr_item_t item3_r;
  logic v3_r;
  // Stage 4: rounded normal impulse term.
  logic [DPW-1:0] dmag;
  logic [DPW-1:0] tsum;
  logic [TMW-1:0] t4_r;
  logic tneg4_r;
  icr_item_t item4_r;
  logic v4_r;
  // Stage 5: numerators of the mass split.
  logic [NW-1:0] num5_r [NUM_LANES];
  logic tneg5_r;
  icr_item_t item5_r;
  logic v5_r;
  // Stage 6: rounding offset and divisor.
  logic [SW-1:0] dvsr6_nxt;
  logic [SW-1:0] dvsr6_r;
  logic [NW-1:0] num6_r [NUM_LANES];
  logic tneg6_r;
  icr_item_t item6_r;
  logic v6_r;
  // Divider delay line.
  logic [QW-1:0] quo [NUM_LANES];
  icr_item_t dly_item_r [QW];
  logic [QW-1:0] dly_tneg_r;
  logic [QW-1:0] dly_vld_r;
  // Stage 7: products with the normal.
  logic [CB-1:0] nmag7 [3];
  logic [PW2-1:0] p7_r [NUM_LANES][3];
  logic [AMW-1:0] am7_r [3];
  logic tneg7_r;
  icr_item_t item7_r;
  logic v7_r;
  // Stage 8: rounding.
  logic [AMW:0] asum8 [3];
  logic [RW-1:0] r8_r [NUM_LANES][3];
  logic [ARW-1:0] ar8_r [3];
  logic tneg8_r;
  icr_item_t item8_r;
  logic v8_r;
  // Output register.
  logic [CB-1:0] ova [3];
  logic [CB-1:0] ovb [3];
  logic [CB-1:0] opa [3];
  logic [CB-1:0] opb [3];
  logic signed [CB-1:0] oab [3];
  logic signed [CB-1:0] ar_s [3];
  logic [FIELD_W-1:0] pk_va;
  logic [FIELD_W-1:0] pk_vb;
  logic [FIELD_W-1:0] pk_pa;
  logic [FIELD_W-1:0] pk_pb;
  logic [FIELD_W-1:0] pk_ab;
  logic [FIELD_W-1:0] out_va_r;
  logic [FIELD_W-1:0] out_vb_r;
  logic [FIELD_W-1:0] out_pa_r;
  logic [FIELD_W-1:0] out_pb_r;
  logic [FIELD_W-1:0] out_ab_r;
  logic out_vld_r;

  // The whole pipeline advances together whenever the output register can take data.
  assign en        = !out_vld_r || out_pop;
  assign q_pop     = en && q_vld;
  assign out_empty = !out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= E_RESET;
    end else if (cfg_we) begin
      rest_r <= cfg_restitution;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif1[i]      = DFW'(comp(q_item.vel_a, i)) - DFW'(comp(q_item.vel_b, i));
      prod1_nxt[i] = dif1[i] * comp(q_item.normal, i);
    end
  end

  assign ep   = ONE_Q10 + EP_W'(rest_r);
  assign ep_s = $signed({1'b0, ep});
  assign dmag = dp3_r[DPW-1] ? (~dp3_r + 1'b1) : dp3_r;
  assign tsum = dmag + (DPW'(1) << (FB + E_SH - 1));
  assign dvsr6_nxt = SW'(item5_r.mass_a) + SW'(item5_r.mass_b);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag7[i] = mag(comp(dly_item_r[QW-1].normal, i));
      asum8[i] = (AMW+1)'(am7_r[i]) + ((AMW+1)'(1) << (ACC_SH - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= prod1_nxt;
      item1_r <= q_item;

      dot2_r  <= DOTW'(prod1_r[0]) + DOTW'(prod1_r[1]) + DOTW'(prod1_r[2]);
      item2_r <= item1_r;

      dp3_r   <= dot2_r * ep_s;
      item3_r <= item2_r;

      t4_r    <= tsum[DPW-1:FB+E_SH];
      tneg4_r <= dp3_r[DPW-1];
      item4_r <= item3_r;

      num5_r[L_KA] <= NW'(t4_r) * NW'(item4_r.mass_b);
      num5_r[L_KB] <= NW'(t4_r) * NW'(item4_r.mass_a);
      num5_r[L_DA] <= NW'(item4_r.depth) * NW'(item4_r.mass_b);
      num5_r[L_DB] <= NW'(item4_r.depth) * NW'(item4_r.mass_a);
      tneg5_r <= tneg4_r;
      item5_r <= item4_r;

      dvsr6_r <= dvsr6_nxt;
      for (int l = 0; l < NUM_LANES; l++) begin
        num6_r[l] <= num5_r[l] + NW'(dvsr6_nxt >> 1);
      end
      tneg6_r <= tneg5_r;
      item6_r <= item5_r;

      dly_item_r[0] <= item6_r;
      for (int k = 1; k < QW; k++) begin
        dly_item_r[k] <= dly_item_r[k-1];
      end
      dly_tneg_r <= {dly_tneg_r[QW-2:0], tneg6_r};

      for (int l = 0; l < NUM_LANES; l++) begin
        for (int i = 0; i < 3; i++) begin
          p7_r[l][i] <= PW2'(quo[l]) * PW2'(nmag7[i]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        am7_r[i] <= AMW'(mag(comp(dly_item_r[QW-1].accel_a, i))) * AMW'(NEG_TENTH);
      end
      tneg7_r <= dly_tneg_r[QW-1];
      item7_r <= dly_item_r[QW-1];

      for (int l = 0; l < NUM_LANES; l++) begin
        for (int i = 0; i < 3; i++) begin
          r8_r[l][i] <= rnd(p7_r[l][i]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        ar8_r[i] <= asum8[i][AMW:ACC_SH];
      end
      tneg8_r <= tneg7_r;
      item8_r <= item7_r;

      out_va_r <= pk_va;
      out_vb_r <= pk_vb;
      out_pa_r <= pk_pa;
      out_pb_r <= pk_pb;
      out_ab_r <= pk_ab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      dly_vld_r <= '0;
      v7_r      <= 1'b0;
      v8_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v1_r      <= q_vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      v6_r      <= v5_r;
      dly_vld_r <= {dly_vld_r[QW-2:0], v6_r};
      v7_r      <= dly_vld_r[QW-1];
      v8_r      <= v7_r;
      out_vld_r <= v8_r;
    end
  end

  icr_div #(
    .QW    (QW),
    .SW    (SW),
    .LANES (NUM_LANES)
  ) u_div (
    .clk  (clk),
    .en   (en),
    .dvsr (dvsr6_r),
    .num  (num6_r),
    .quo  (quo)
  );

  // The impulse on A opposes the normal term, the one on B follows it; the signs of
  // the impulse and of each normal component decide add or subtract.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ova[i]  = apply(comp(item8_r.vel_a, i), r8_r[L_KA][i],
                      !(tneg8_r ^ item8_r.normal[i*CB + CB - 1]));
      ovb[i]  = apply(comp(item8_r.vel_b, i), r8_r[L_KB][i],
                      tneg8_r ^ item8_r.normal[i*CB + CB - 1]);
      opa[i]  = apply(comp(item8_r.pos_a, i), r8_r[L_DA][i],
                      item8_r.normal[i*CB + CB - 1]);
      opb[i]  = apply(comp(item8_r.pos_b, i), r8_r[L_DB][i],
                      !item8_r.normal[i*CB + CB - 1]);
      ar_s[i] = $signed(CB'(ar8_r[i]));
      oab[i]  = item8_r.accel_a[i*CB + CB - 1] ? ar_s[i] : -ar_s[i];
    end
  end

  always_comb begin
    pk_va = '0;
    pk_vb = '0;
    pk_pa = '0;
    pk_pb = '0;
    pk_ab = '0;
    for (int i = 0; i < 3; i++) begin
      pk_va[i*CB +: CB] = ova[i];
      pk_vb[i*CB +: CB] = ovb[i];
      pk_pa[i*CB +: CB] = opa[i];
      pk_pb[i*CB +: CB] = opb[i];
      pk_ab[i*CB +: CB] = oab[i];
    end
    if (item8_r.static_a) begin
      pk_va = item8_r.vel_a;
      pk_pa = item8_r.pos_a;
    end
    if (item8_r.static_b) begin
      pk_vb = item8_r.vel_b;
      pk_pb = item8_r.pos_b;
      pk_ab = item8_r.accel_b;
    end
  end

  assign new_vel_a   = out_va_r;
  assign new_vel_b   = out_vb_r;
  assign new_pos_a   = out_pa_r;
  assign new_pos_b   = out_pb_r;
  assign new_accel_b = out_ab_r;

  `ICR_ASSERT_NEXT(a_out_hold, out_vld_r && !out_pop,
                   out_vld_r && $stable(out_va_r) && $stable(out_ab_r),
                   "waiting result changed before it was taken")
  `ICR_ASSERT_NEXT(a_stall_freeze, !en, $stable(v6_r) && $stable(dly_vld_r),
                   "pipeline moved during a stall")
  `ICR_ASSERT_NEXT(a_last_stage, en && v8_r, out_vld_r,
                   "finished contact was not registered at the output")

endmodule

@@ hdl/impulse_contact_resolver.sv @@
// Top level of the impulse contact resolver.
//
// Each input transaction carries one contact between bodies A and B; each
// produces exactly one result transaction with resolved velocities, separated
// positions and B's new acceleration, in input order.
// Input: present a contact with in_push high; it is taken on a clock edge where
// in_full is low. Output: the oldest result sits on the out_ ports while
// out_empty is low and is taken on an edge with out_pop high.
// cfg_we writes the restitution coefficient; write it only while the block is idle.
// Throughput is one contact per cycle while waiting results are popped. The
// mass-split divider has a quotient width of QW and resolves one bit per stage.
// Synchronous reset empties the input queue and the pipeline and sets the
// restitution to its default of 102/1024.
// When a waiting result is not popped, the pipeline holds in place and the two-entry
// input queue fills, after which in_full rises.
module impulse_contact_resolver #(
  parameter int COMPONENT_BITS = 21,
  parameter int FRACTION_BITS  = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [icr_pkg::E_W-1:0]     cfg_restitution,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [icr_pkg::FIELD_W-1:0] in_vel_a,
  input  logic [icr_pkg::FIELD_W-1:0] in_vel_b,
  input  logic [icr_pkg::FIELD_W-1:0] in_pos_a,
  input  logic [icr_pkg::FIELD_W-1:0] in_pos_b,
  input  logic [icr_pkg::FIELD_W-1:0] in_contact_normal,
  input  logic [icr_pkg::MASS_W-1:0]  in_depth,
  input  logic [icr_pkg::MASS_W-1:0]  in_mass_a,
  input  logic [icr_pkg::MASS_W-1:0]  in_mass_b,
  input  logic                        in_static_a,
  input  logic                        in_static_b,
  input  logic [icr_pkg::FIELD_W-1:0] in_accel_a,
  input  logic [icr_pkg::FIELD_W-1:0] in_accel_b,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [icr_pkg::FIELD_W-1:0] out_new_vel_a,
  output logic [icr_pkg::FIELD_W-1:0] out_new_vel_b,
  output logic [icr_pkg::FIELD_W-1:0] out_new_pos_a,
  output logic [icr_pkg::FIELD_W-1:0] out_new_pos_b,
  output logic [icr_pkg::FIELD_W-1:0] out_new_accel_b
);
  import icr_pkg::*;

  icr_item_t in_item;
  icr_item_t q_item;
  logic      q_vld;
  logic      q_pop;

  always_comb begin
    in_item.vel_a    = in_vel_a;
    in_item.vel_b    = in_vel_b;
    in_item.pos_a    = in_pos_a;
    in_item.pos_b    = in_pos_b;
    in_item.normal   = in_contact_normal;
    in_item.accel_a  = in_accel_a;
    in_item.accel_b  = in_accel_b;
    in_item.depth    = in_depth;
    in_item.mass_a   = in_mass_a;
    in_item.mass_b   = in_mass_b;
    in_item.static_a = in_static_a;
    in_item.static_b = in_static_b;
  end

  icr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_vld   (q_vld),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  icr_back #(
    .CB (COMPONENT_BITS),
    .FB (FRACTION_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_restitution (cfg_restitution),
    .q_vld           (q_vld),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .new_vel_a       (out_new_vel_a),
    .new_vel_b       (out_new_vel_b),
    .new_pos_a       (out_new_pos_a),
    .new_pos_b       (out_new_pos_b),
    .new_accel_b     (out_new_accel_b)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the impulse contact resolver with a contact scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icr_pkg::*;

  localparam int CB      = 21;
  localparam int FB      = 10;
  localparam int LATENCY = 58;
  localparam int LIMIT   = 1000000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [FIELD_W-1:0] vel_a, vel_b, pos_a, pos_b, normal, accel_a, accel_b;
    logic [MASS_W-1:0]  depth, mass_a, mass_b;
    logic               static_a, static_b;
  } contact_t;

  typedef struct {
    logic [FIELD_W-1:0] vel_a, vel_b, pos_a, pos_b, accel_b;
  } resolution_t;

  class contact_scoreboard;
    logic [E_W-1:0] restitution;
    resolution_t    pending[$];
    int             errors;

    function new();
      restitution = E_RESET;
      errors      = 0;
    endfunction

    static function wide_t round_div(wide_t num, wide_t den);
      wide_t mag, q;
      mag = (num < 0) ? -num : num;
      q   = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    static function wide_t comp(logic [FIELD_W-1:0] f, int i);
      return wide_t'($signed(f[i*CB +: CB]));
    endfunction

    static function logic [CB-1:0] clamp(wide_t x);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (CB - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) x = hi;
      if (x < lo) x = lo;
      return x[CB-1:0];
    endfunction

    // Computes the resolution of one accepted contact and queues it.
    function void note_contact(contact_t c);
      wide_t dot, t, ka, kb, da, db, ma, mb, s, n;
      resolution_t r;
      logic [FIELD_W-1:0] va, vb, pa, pb, ab;
      dot = 0;
      for (int i = 0; i < 3; i++)
        dot += (comp(c.vel_a, i) - comp(c.vel_b, i)) * comp(c.normal, i);
      ma = (c.mass_a == 0) ? 1 : c.mass_a;
      mb = (c.mass_b == 0) ? 1 : c.mass_b;
      s  = ma + mb;
      t  = round_div(dot * (1024 + wide_t'(restitution)), wide_t'(1) <<< (FB + 10));
      ka = round_div(t * mb, s);
      kb = round_div(t * ma, s);
      da = round_div(wide_t'(c.depth) * mb, s);
      db = round_div(wide_t'(c.depth) * ma, s);
      va = '0; vb = '0; pa = '0; pb = '0; ab = '0;
      for (int i = 0; i < 3; i++) begin
        n = comp(c.normal, i);
        va[i*CB +: CB] = clamp(comp(c.vel_a, i) - round_div(ka * n, 1 << FB));
        vb[i*CB +: CB] = clamp(comp(c.vel_b, i) + round_div(kb * n, 1 << FB));
        pa[i*CB +: CB] = clamp(comp(c.pos_a, i) + round_div(da * n, 1 << FB));
        pb[i*CB +: CB] = clamp(comp(c.pos_b, i) - round_div(db * n, 1 << FB));
        ab[i*CB +: CB] = clamp(round_div(-comp(c.accel_a, i) * NEG_TENTH, 1024));
      end
      // A static body keeps its raw fields, unused high bits included.
      r.vel_a   = c.static_a ? c.vel_a : va;
      r.pos_a   = c.static_a ? c.pos_a : pa;
      r.vel_b   = c.static_b ? c.vel_b : vb;
      r.pos_b   = c.static_b ? c.pos_b : pb;
      r.accel_b = c.static_b ? c.accel_b : ab;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(resolution_t got);
      resolution_t exp;
      if (pending.size() == 0) begin
        $error("result transaction with no contact outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.vel_a !== exp.vel_a) begin
        $error("new_vel_a expected %h actual %h", exp.vel_a, got.vel_a); errors++;
      end
      if (got.vel_b !== exp.vel_b) begin
        $error("new_vel_b expected %h actual %h", exp.vel_b, got.vel_b); errors++;
      end
      if (got.pos_a !== exp.pos_a) begin
        $error("new_pos_a expected %h actual %h", exp.pos_a, got.pos_a); errors++;
      end
      if (got.pos_b !== exp.pos_b) begin
        $error("new_pos_b expected %h actual %h", exp.pos_b, got.pos_b); errors++;
      end
      if (got.accel_b !== exp.accel_b) begin
        $error("new_accel_b expected %h actual %h", exp.accel_b, got.accel_b); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [E_W-1:0] cfg_restitution;
  logic in_push, in_full, in_static_a, in_static_b;
  logic [FIELD_W-1:0] in_vel_a, in_vel_b, in_pos_a, in_pos_b, in_contact_normal;
  logic [FIELD_W-1:0] in_accel_a, in_accel_b;
  logic [MASS_W-1:0]  in_depth, in_mass_a, in_mass_b;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [FIELD_W-1:0] out_new_vel_a, out_new_vel_b, out_new_pos_a, out_new_pos_b;
  logic [FIELD_W-1:0] out_new_accel_b;

  contact_scoreboard sb = new();
  int  cycle_count = 0;
  bit  hold_request = 0;
  bit  hold_done = 0;
  int  hold_left = 0;
  int  stall_mode = 0;
  int  burst_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  impulse_contact_resolver i_dut (
    .clk, .rst_n, .cfg_we, .cfg_restitution,
    .in_push, .in_full, .in_vel_a, .in_vel_b, .in_pos_a, .in_pos_b,
    .in_contact_normal, .in_depth, .in_mass_a, .in_mass_b,
    .in_static_a, .in_static_b, .in_accel_a, .in_accel_b,
    .out_empty, .out_pop, .out_new_vel_a, .out_new_vel_b,
    .out_new_pos_a, .out_new_pos_b, .out_new_accel_b
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: check each popped transaction, then pick the next pop value.
  always @(posedge clk) begin
    resolution_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.vel_a   = out_new_vel_a;
      got.vel_b   = out_new_vel_b;
      got.pos_a   = out_new_pos_a;
      got.pos_b   = out_new_pos_b;
      got.accel_b = out_new_accel_b;
      sb.check_result(got);
    end
    if (hold_request && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
    end
    if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (stall_mode == 0) begin
      out_pop <= 1'b1;
    end else if (stall_mode == 1) begin
      out_pop <= 1'($urandom_range(0, 1));
    end else begin
      out_pop <= (cycle_count % 7) < 3;
    end
  end

  function automatic logic [FIELD_W-1:0] rand_field();
    return FIELD_W'({$urandom(), $urandom()});
  endfunction

  // Three small packed components, mostly sensible magnitudes.
  function automatic logic [FIELD_W-1:0] rand_vector(int span);
    logic [FIELD_W-1:0] f;
    f = '0;
    for (int i = 0; i < 3; i++)
      f[i*CB +: CB] = CB'($signed($urandom_range(0, 2 * span)) - span);
    return f;
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    bit noisy;
    noisy = ($urandom_range(0, 3) == 0);
    if (noisy) begin
      c.vel_a = rand_field(); c.vel_b = rand_field(); c.pos_a = rand_field();
      c.pos_b = rand_field(); c.normal = rand_field();
      c.accel_a = rand_field(); c.accel_b = rand_field();
      c.depth  = MASS_W'($urandom());
      c.mass_a = MASS_W'($urandom());
      c.mass_b = MASS_W'($urandom());
    end else begin
      c.vel_a   = rand_vector(8192);
      c.vel_b   = rand_vector(8192);
      c.pos_a   = rand_vector(500000);
      c.pos_b   = rand_vector(500000);
      c.normal  = rand_vector(1024);
      c.accel_a = rand_vector(20000);
      c.accel_b = rand_vector(20000);
      c.depth   = MASS_W'($urandom_range(0, 4096));
      c.mass_a  = MASS_W'($urandom_range(1, 65536));
      c.mass_b  = MASS_W'($urandom_range(1, 65536));
    end
    c.static_a = ($urandom_range(0, 4) == 0);
    c.static_b = ($urandom_range(0, 4) == 0);
    return c;
  endfunction

  task automatic send_contact(contact_t c);
    in_vel_a          <= c.vel_a;
    in_vel_b          <= c.vel_b;
    in_pos_a          <= c.pos_a;
    in_pos_b          <= c.pos_b;
    in_contact_normal <= c.normal;
    in_accel_a        <= c.accel_a;
    in_accel_b        <= c.accel_b;
    in_depth          <= c.depth;
    in_mass_a         <= c.mass_a;
    in_mass_b         <= c.mass_b;
    in_static_a       <= c.static_a;
    in_static_b       <= c.static_b;
    in_push           <= 1'b1;
    do @(posedge clk); while (in_full);
    sb.note_contact(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic write_restitution(logic [E_W-1:0] value);
    in_push <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_restitution <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.restitution = value;
  endtask

  initial begin
    contact_t c;
    logic [FIELD_W-1:0] ones;
    logic [E_W-1:0] settings[6];
    ones = '1;
    rst_n <= 1'b0; cfg_we <= 1'b0; cfg_restitution <= '0; in_push <= 1'b0;
    in_vel_a <= '0; in_vel_b <= '0; in_pos_a <= '0; in_pos_b <= '0;
    in_contact_normal <= '0; in_accel_a <= '0; in_accel_b <= '0;
    in_depth <= '0; in_mass_a <= '0; in_mass_b <= '0;
    in_static_a <= 1'b0; in_static_b <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed contacts at the reset restitution: extremes, static bodies, zero mass.
    for (int k = 0; k < 20; k++) begin
      c = rand_contact();
      c.static_a = k[0];
      c.static_b = k[1];
      case (k / 4)
        0: begin
          c.vel_a = '0; c.vel_b = '0; c.pos_a = '0; c.pos_b = '0; c.normal = '0;
          c.accel_a = '0; c.accel_b = '0; c.depth = '0; c.mass_a = '0; c.mass_b = '0;
        end
        1: begin
          c.vel_a = ones; c.vel_b = ones; c.pos_a = ones; c.pos_b = ones;
          c.normal = ones; c.accel_a = ones; c.accel_b = ones;
          c.depth = '1; c.mass_a = '1; c.mass_b = '1;
        end
        2: begin
          // Most positive against most negative components drives saturation.
          c.vel_a = {3{1'b0, {(CB-1){1'b1}}}};
          c.vel_b = {3{1'b1, {(CB-1){1'b0}}}};
          c.pos_a = c.vel_a; c.pos_b = c.vel_b;
          c.normal = {3{1'b0, {(CB-1){1'b1}}}};
          c.accel_a = c.vel_b; c.depth = '1; c.mass_a = MASS_W'(1); c.mass_b = '1;
        end
        3: begin
          c.mass_a = '1; c.mass_b = '0;
          c.accel_a = {3{1'b0, {(CB-1){1'b1}}}};
        end
        default: begin
          c.normal = {{(FIELD_W-CB){1'b0}}, CB'(1024)};
          c.vel_a[FIELD_W-1] = 1'b1; c.pos_b[FIELD_W-1] = 1'b1;
        end
      endcase
      send_contact(c);
    end

    settings = '{11'd0, 11'd1024, 11'd2047, 11'd102, 11'd1, 11'd0};
    settings[5] = E_W'($urandom_range(0, 2047));
    for (int p = 0; p < 6; p++) begin
      write_restitution(settings[p]);
      for (int k = 0; k < 300; k++) begin
        if (p == 2 && k == 100) hold_request = 1;
        send_contact(rand_contact());
      end
    end
    in_push <= 1'b0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/icr_pkg.sv
hdl/icr_div.sv
hdl/icr_front.sv
hdl/icr_back.sv
hdl/impulse_contact_resolver.sv
tb/sv/tb_top.sv
